// ----- rtl/bal_pkg.sv -----
package bal_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_INSERT     = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_POP_FRONT  = 3'd4;
  localparam logic [2:0] OP_REMOVE     = 3'd5;
  localparam logic [2:0] OP_FIND       = 3'd6;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] value;
    logic [4:0]               index;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [3:0] position;
    logic [4:0] count;
  } res_t;

  // Broadcast to every cell: open a slot at 'at' or close the slot at 'at'.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] at;
  } ctrl_t;

endpackage

// ----- rtl/bal_cell.sv -----
module bal_cell (
  input  logic                      clk_i,
  input  bal_pkg::ctrl_t            ctrl_i,
  input  logic [bal_pkg::IDX_W-1:0] pos_i,
  input  logic [bal_pkg::DATA_W-1:0] value_i,
  input  logic [bal_pkg::DATA_W-1:0] left_i,
  input  logic [bal_pkg::DATA_W-1:0] right_i,
  output logic [bal_pkg::DATA_W-1:0] data_o,
  output logic                      match_o
);
  import bal_pkg::*;

  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (pos_i == ctrl_i.at) begin
        data_d = value_i;
      end else if (pos_i > ctrl_i.at) begin
        data_d = left_i;
      end
    end else if (ctrl_i.del) begin
      if (pos_i >= ctrl_i.at) begin
        data_d = right_i;
      end
    end
  end

  // Payload only, no reset needed.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == value_i);

endmodule

// ----- rtl/bounded_array_list.sv -----
// Result: a command accepted at one clock edge has its result on res_o, with
// done_o high, during the next cycle.
// Throughput: one command per cycle; busy_o stays low, the cell row shifts
// and compares every entry in the same cycle. The receiver cannot stall.
// Reset: rst_ni clears the entry count and the result strobe at once; the
// entry words themselves are not reset and are read only below the count.
module bounded_array_list (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  bal_pkg::cmd_t cmd_i,
  output logic          done_o,
  output bal_pkg::res_t res_o
);
  import bal_pkg::*;

  // Accept handshake: the list never blocks a command.
  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  logic [CNT_W-1:0] count_q, count_d;
  logic             full, empty;
  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  // Decode the command into a slot open / slot close for the cell row.
  logic             ins, del;
  logic [IDX_W-1:0] at;
  logic [1:0]       status;
  logic [CNT_W-1:0] cnt_next;

  always_comb begin
    ins      = 1'b0;
    del      = 1'b0;
    at       = '0;
    status   = ST_DONE;
    cnt_next = count_q;
    unique case (cmd_i.op)
      OP_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          // Opening a slot at the count is a plain append.
          ins      = 1'b1;
          at       = IDX_W'(count_q);
          cnt_next = count_q + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ins      = 1'b1;
          cnt_next = count_q + 1'b1;
        end
      end
      OP_INSERT: begin
        // Bad index is checked before full.
        if (32'(cmd_i.index) > 32'(count_q)) begin
          status = ST_BAD;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ins      = 1'b1;
          at       = IDX_W'(cmd_i.index);
          cnt_next = count_q + 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status = ST_BAD;
        end else begin
          cnt_next = count_q - 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status = ST_BAD;
        end else begin
          del      = 1'b1;
          cnt_next = count_q - 1'b1;
        end
      end
      OP_REMOVE: begin
        // Covers remove on an empty list too.
        if (32'(cmd_i.index) >= 32'(count_q)) begin
          status = ST_BAD;
        end else begin
          del      = 1'b1;
          at       = IDX_W'(cmd_i.index);
          cnt_next = count_q - 1'b1;
        end
      end
      OP_FIND: begin
        // Read only; handled by the match vector below.
      end
      default: begin
        status = ST_BAD;
      end
    endcase
  end

  ctrl_t ctrl;
  assign ctrl.ins = accept && ins;
  assign ctrl.del = accept && del;
  assign ctrl.at  = at;

  // Cell row: each cell talks to its lower and upper neighbor.
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]  cell_match;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = cmd_i.value;        // unused: cell 0 loads value_i on an open at 0
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];      // top cell keeps its word on a close
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    bal_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (IDX_W'(i)),
      .value_i (cmd_i.value),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .match_o (cell_match[i])
    );
  end

  // Lowest live matching position; live means below the count.
  logic       hit;
  logic [3:0] hit_pos;
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cell_match[i] && (32'(i) < 32'(count_q))) begin
        hit     = 1'b1;
        hit_pos = 4'(i);
      end
    end
  end

  logic is_find;
  assign is_find = (cmd_i.op == OP_FIND);

  assign count_d = accept ? cnt_next : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_o  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_o  <= accept;
    end
  end

  // Result payload, qualified by done_o.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_o.status   <= status;
      res_o.found    <= is_find && hit;
      res_o.position <= is_find ? hit_pos : 4'd0;
      res_o.count    <= 5'(cnt_next);
    end
  end

endmodule

// ----- rtl/bal_checker.sv -----
module bal_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input bal_pkg::cmd_t cmd_i,
  input logic          done_o,
  input bal_pkg::res_t res_o
);
  import bal_pkg::*;

  // Every accepted transaction gives exactly one result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result without an accepted transaction");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == ST_FULL) |-> (res_o.count == 5'(DEPTH)))
    else $error("full rejection while count below depth");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.found) |->
      (res_o.status == ST_DONE && 32'(res_o.position) < 32'(res_o.count)))
    else $error("found position outside the live entries");

  a_not_found_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.found) |-> (res_o.position == 4'd0))
    else $error("nonzero position without a match");

endmodule

bind bounded_array_list bal_checker u_bal_checker (.*);
